// ----- hdl/srcm_pkg.sv -----
`default_nettype none

package srcm_pkg;

    localparam int DEFAULT_VALUE_BITS = 16;

    // reset contents of the configuration registers
    localparam logic [31:0] RESET_MODULUS = 32'd3233;
    localparam logic [31:0] RESET_PUBLIC  = 32'd17;
    localparam logic [31:0] RESET_PRIVATE = 32'd2753;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE = 2'd2;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic load;           // capture request, select exponent, start base reduction
        logic red_step;       // one radix-4 reduction step
        logic mul_sq;         // product <= acc * acc, start reduction
        logic mul_base;       // product <= acc * base, start reduction
        logic base_from_rem;
        logic acc_from_rem;
        logic exp_shift;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic red_busy;
        logic exp_msb;
        logic m_small;        // modulus below two
    } sts_t;

endpackage

`default_nettype wire

// ----- hdl/srcm_dp.sv -----
`default_nettype none

module srcm_dp #(
    parameter int VALUE_BITS = srcm_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [srcm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [VALUE_BITS-1:0]          cfg_data,
    input  wire logic                           item_op,
    input  wire logic [VALUE_BITS-1:0]          item_value,
    input  wire srcm_pkg::cmd_t                 cmd,
    output srcm_pkg::sts_t                      sts,
    output logic [VALUE_BITS-1:0]               result
);
    import srcm_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int PW = 2 * VALUE_BITS;
    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VB-1:0]   modulus_reg;
    logic [VB-1:0]   public_reg;
    logic [VB-1:0]   private_reg;
    logic [VB-1:0]   base_reg;
    logic [VB-1:0]   acc_reg;
    logic [VB-1:0]   exp_reg;
    logic [VB-1:0]   rem_reg;
    logic [VB-1:0]   rem_next;
    logic [VB-1:0]   result_reg;
    logic [VB+1:0]   m3_reg;
    logic [PW-1:0]   prod_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;

    logic [VB+1:0]   m1;
    logic [VB+1:0]   m2;
    logic [VB+1:0]   t;
    logic [VB-1:0]   mul_b;
    logic [PW-1:0]   mul_p;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= VB'(RESET_MODULUS);
            public_reg  <= VB'(RESET_PUBLIC);
            private_reg <= VB'(RESET_PRIVATE);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODULUS: modulus_reg <= cfg_data;
                CFG_PUBLIC:  public_reg  <= cfg_data;
                CFG_PRIVATE: private_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign m1 = {2'b00, modulus_reg};
    assign m2 = {1'b0, modulus_reg, 1'b0};

    // radix-4 restoring reduction: two product bits per step, remainder stays below m
    assign t = {rem_reg, prod_reg[PW-1 -: 2]};

    always_comb
    begin
        if (t >= m3_reg)
            rem_next = VB'(t - m3_reg);
        else if (t >= m2)
            rem_next = VB'(t - m2);
        else if (t >= m1)
            rem_next = VB'(t - m1);
        else
            rem_next = VB'(t);
    end

    assign mul_b = cmd.mul_base ? base_reg : acc_reg;
    assign mul_p = acc_reg * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prod_reg <= PW'(item_value);
            rem_reg  <= '0;
            m3_reg   <= m1 + m2;
            exp_reg  <= (item_op == OP_DECRYPT) ? private_reg : public_reg;
            acc_reg  <= sts.m_small ? VB'(0) : VB'(1);
        end
        else
        begin
            if (cmd.mul_sq || cmd.mul_base)
            begin
                prod_reg <= mul_p;
                rem_reg  <= '0;
            end
            else if (cmd.red_step)
            begin
                prod_reg <= prod_reg << 2;
                rem_reg  <= rem_next;
            end
            if (cmd.acc_from_rem)
                acc_reg <= rem_reg;
            if (cmd.exp_shift)
                exp_reg <= exp_reg << 1;
        end
        if (cmd.base_from_rem)
            base_reg <= rem_reg;
        if (cmd.out_load)
            result_reg <= acc_reg;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load || cmd.mul_sq || cmd.mul_base)
            cnt_next = CW'(VB);
        else if (cmd.red_step)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign sts.red_busy = (cnt_reg != '0);
    assign sts.exp_msb  = exp_reg[VB-1];
    assign sts.m_small  = (modulus_reg[VB-1:1] == '0);
    assign result       = result_reg;

endmodule

`default_nettype wire

// ----- hdl/srcm_ctrl.sv -----
`default_nettype none

module srcm_ctrl #(
    parameter int VALUE_BITS = srcm_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    input  wire srcm_pkg::sts_t sts,
    output srcm_pkg::cmd_t      cmd
);
    import srcm_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BRED  = 3'd1;
    localparam logic [2:0] S_SQ    = 3'd2;
    localparam logic [2:0] S_SQRED = 3'd3;
    localparam logic [2:0] S_MB    = 3'd4;
    localparam logic [2:0] S_MBRED = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] bit_cnt_reg;
    logic [CW-1:0] bit_cnt_next;
    logic          started_reg;
    logic          started_next;
    logic          m_valid_reg;
    logic          m_valid_next;

    always_comb
    begin
        cmd          = '0;
        s_tready     = 1'b0;
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        started_next = started_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = CW'(VALUE_BITS);
                    started_next = 1'b0;
                    state_next   = sts.m_small ? S_FIN : S_BRED;
                end
            end
            S_BRED:
            begin
                if (sts.red_busy)
                    cmd.red_step = 1'b1;
                else
                begin
                    cmd.base_from_rem = 1'b1;
                    state_next        = S_SQ;
                end
            end
            S_SQ:
            begin
                // squaring is skipped while acc is still one (leading zero exponent bits)
                if (bit_cnt_reg == '0)
                    state_next = S_FIN;
                else if (started_reg)
                begin
                    cmd.mul_sq = 1'b1;
                    state_next = S_SQRED;
                end
                else
                    state_next = S_MB;
            end
            S_SQRED:
            begin
                if (sts.red_busy)
                    cmd.red_step = 1'b1;
                else
                begin
                    cmd.acc_from_rem = 1'b1;
                    state_next       = S_MB;
                end
            end
            S_MB:
            begin
                if (sts.exp_msb)
                begin
                    cmd.mul_base = 1'b1;
                    started_next = 1'b1;
                    state_next   = S_MBRED;
                end
                else
                begin
                    cmd.exp_shift = 1'b1;
                    bit_cnt_next  = bit_cnt_reg - CW'(1);
                    state_next    = S_SQ;
                end
            end
            S_MBRED:
            begin
                if (sts.red_busy)
                    cmd.red_step = 1'b1;
                else
                begin
                    cmd.acc_from_rem = 1'b1;
                    cmd.exp_shift    = 1'b1;
                    bit_cnt_next     = bit_cnt_reg - CW'(1);
                    state_next       = S_SQ;
                end
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bit_cnt_reg <= '0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while still pending");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("request accepted but controller stayed idle");

    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= CW'(VALUE_BITS))
        else $error("exponent bit counter out of range");

    a_step_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.red_step |-> sts.red_busy)
        else $error("reduction step issued with no reduction running");

    a_single_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_sq || cmd.mul_base) |=> sts.red_busy)
        else $error("multiply did not start a reduction");

endmodule

`default_nettype wire

// ----- hdl/small_rsa_char_modexp_unit.sv -----
`default_nettype none
// Operation: base reduction first, then per exponent bit from the MSB: leading zero bits skip
//   squaring, the leading one bit multiplies by the base unsquared, each later bit squares and,
//   if one, multiplies by the base; a modulus below two goes straight to S_FIN with result zero.
// Requests: one at a time, the next accepted from the cycle after the result is loaded; each
//   modular multiply uses the shared multiplier and the radix-4 reducer, in VALUE_BITS steps.
// Reset (rst_n, async low): modulus 3233, exponents 17 and 2753, controller idle, no result.

module small_rsa_char_modexp_unit #(
    parameter int VALUE_BITS = srcm_pkg::DEFAULT_VALUE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [srcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [VALUE_BITS-1:0]           cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0] s_tdata,   // value
    input  wire logic                            s_tuser,   // op
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0]      m_tdata    // result_value
);
    import srcm_pkg::*;

    localparam int DW = ((VALUE_BITS + 7) / 8) * 8;

    cmd_t                  cmd;
    sts_t                  sts;
    logic [VALUE_BITS-1:0] result;

    srcm_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srcm_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_op    (s_tuser),
        .item_value (s_tdata[VALUE_BITS-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .result     (result)
    );

    assign m_tdata = DW'(result);

endmodule

`default_nettype wire
